[src/vfra_pkg.sv]
// Shared types and constants for the variable frame ring allocator.
// No dependencies; every other file of the block uses this package.
package vfra_pkg;

  localparam int unsigned POOL_BYTES    = 65536;
  localparam int unsigned DESC_DEPTH    = 32;
  localparam int unsigned DEFAULT_LIMIT = 30;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 3'd0,
    OP_COMMIT  = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_PEEK    = 3'd3,
    OP_RELEASE = 3'd4,
    OP_UNHOLD  = 3'd5,
    OP_CLEAR   = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_NO_RES   = 3'd3,
    ST_FULL     = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_NOT_HELD = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_SIZE   = 2'd0,
    CFG_QUEUE_LIMIT = 2'd1
  } cfg_idx_e;

endpackage

[src/vfra_if.sv]
// Valid/ready channel interfaces for the frame ring allocator:
// operation words in, result words out, configuration writes in.
// Depends on vfra_pkg.
interface vfra_op_if #(
  parameter int unsigned LenW = $clog2(vfra_pkg::POOL_BYTES) + 1
);
  logic                      valid;
  logic                      ready;
  logic [vfra_pkg::OP_W-1:0] operation;
  logic [LenW-1:0]           frame_bytes;

  modport source (output valid, operation, frame_bytes, input ready);
  modport sink   (input valid, operation, frame_bytes, output ready);
endinterface

interface vfra_res_if #(
  parameter int unsigned OffW = $clog2(vfra_pkg::POOL_BYTES),
  parameter int unsigned CntW = $clog2(vfra_pkg::DESC_DEPTH + 1)
);
  logic                          valid;
  logic                          ready;
  logic [vfra_pkg::STATUS_W-1:0] status;
  logic [OffW-1:0]               frame_offset;
  logic [OffW:0]                 frame_length;
  logic [CntW-1:0]               item_count;

  modport source (output valid, status, frame_offset, frame_length, item_count,
                  input ready);
  modport sink   (input valid, status, frame_offset, frame_length, item_count,
                  output ready);
endinterface

interface vfra_cfg_if #(
  parameter int unsigned DataW = $clog2(vfra_pkg::POOL_BYTES) + 1
);
  logic                           valid;
  logic                           ready;
  logic [vfra_pkg::CFG_IDX_W-1:0] index;
  logic [DataW-1:0]               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/variable_frame_ring_allocator_core.sv]
// Top level of the variable frame ring allocator: input and result
// registers, configuration registers, control and descriptor memory.
// Depends on vfra_pkg, vfra_if, vfra_ctrl and vfra_desc_store.
//
// Usage:
//   op_i   carries one operation word (operation, frame_bytes) per handshake.
//   res_o  returns exactly one result word (status, frame_offset,
//          frame_length, item_count) for every operation word, in order.
//   cfg_i  writes pool_size (index 0) or queue_limit (index 1); other
//          indexes are ignored. It is always ready; write it only while idle.
// Pipeline: a word taken on op_i waits in the input register, is executed
//   from there into the result register, and that register drives res_o.
// Throughput: one operation per cycle unless res_o stalls; each operation is
//   one pass of compares and adds over the state registers plus one descriptor
//   read, served from a head entry register that the memory refreshes each cycle.
// Reset: state, queue pointers and counts clear at once; pool_size resets
//   to the pool size and queue_limit to the default limit. The descriptor
//   memory is not cleared; only written entries are ever returned.
// Stall: when res_o is not ready the result register holds, one more word
//   waits in the input register, and op_i deasserts ready after that.
module variable_frame_ring_allocator_core #(
  parameter int unsigned PoolBytes = vfra_pkg::POOL_BYTES,
  parameter int unsigned DescDepth = vfra_pkg::DESC_DEPTH,
  parameter int unsigned OffW      = $clog2(PoolBytes),
  parameter int unsigned CntW      = $clog2(DescDepth + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  vfra_op_if.sink    op_i,
  vfra_res_if.source res_o,
  vfra_cfg_if.sink   cfg_i
);
  import vfra_pkg::*;

  localparam int unsigned LenW   = OffW + 1;
  localparam int unsigned IdxW   = $clog2(DescDepth);
  localparam int unsigned DefLim = (DEFAULT_LIMIT > DescDepth) ? DescDepth : DEFAULT_LIMIT;

  logic            s1_valid_q, s1_valid_d;
  logic [OP_W-1:0] s1_op_q;
  logic [LenW-1:0] s1_bytes_q;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q;
  logic [OffW-1:0] out_off_q;
  logic [LenW-1:0] out_len_q;
  logic [CntW-1:0] out_cnt_q;
  logic [LenW-1:0] pool_size_q;
  logic [CntW-1:0] queue_limit_q;

  logic            out_free;
  logic            exec;
  logic            in_take;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [OffW-1:0] wr_off;
  logic [LenW-1:0] wr_len;
  logic [IdxW-1:0] rd_addr;
  logic [OffW-1:0] head_off;
  logic [LenW-1:0] head_len;
  status_e         r_status;
  logic [OffW-1:0] r_off;
  logic [LenW-1:0] r_len;
  logic [CntW-1:0] r_cnt;

  assign out_free    = !out_valid_q || res_o.ready;
  assign exec        = s1_valid_q && out_free;
  assign op_i.ready  = !s1_valid_q || out_free;
  assign in_take     = op_i.valid && op_i.ready;
  assign cfg_i.ready = 1'b1;

  assign s1_valid_d  = in_take ? 1'b1 : (exec ? 1'b0 : s1_valid_q);
  assign out_valid_d = exec ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      pool_size_q   <= LenW'(PoolBytes);
      queue_limit_q <= CntW'(DefLim);
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_POOL_SIZE:   pool_size_q   <= cfg_i.data;
          CFG_QUEUE_LIMIT: queue_limit_q <= cfg_i.data[CntW-1:0];
          default: begin
            // drop writes beyond the register list
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q    <= op_i.operation;
      s1_bytes_q <= op_i.frame_bytes;
    end
    if (exec) begin
      out_status_q <= r_status;
      out_off_q    <= r_off;
      out_len_q    <= r_len;
      out_cnt_q    <= r_cnt;
    end
  end

  vfra_ctrl #(
    .PoolBytes (PoolBytes),
    .DescDepth (DescDepth),
    .OffW      (OffW),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .exec_i        (exec),
    .op_i          (op_e'(s1_op_q)),
    .bytes_i       (s1_bytes_q),
    .pool_size_i   (pool_size_q),
    .queue_limit_i (queue_limit_q),
    .head_off_i    (head_off),
    .head_len_i    (head_len),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_off_o      (wr_off),
    .wr_len_o      (wr_len),
    .rd_addr_o     (rd_addr),
    .status_o      (r_status),
    .offset_o      (r_off),
    .length_o      (r_len),
    .count_o       (r_cnt)
  );

  vfra_desc_store #(
    .DescDepth (DescDepth),
    .OffW      (OffW),
    .IdxW      (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_off_i  (wr_off),
    .wr_len_i  (wr_len),
    .rd_addr_i (rd_addr),
    .rd_off_o  (head_off),
    .rd_len_o  (head_len)
  );

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_status_q;
  assign res_o.frame_offset = out_off_q;
  assign res_o.frame_length = out_len_q;
  assign res_o.item_count   = out_cnt_q;

endmodule

[src/vfra_desc_store.sv]
// Descriptor memory of the frame ring allocator: one write port at the tail
// and a registered read of the next head entry, with write bypass.
// Depends on vfra_pkg.
module vfra_desc_store #(
  parameter int unsigned DescDepth = vfra_pkg::DESC_DEPTH,
  parameter int unsigned OffW      = $clog2(vfra_pkg::POOL_BYTES),
  parameter int unsigned IdxW      = $clog2(vfra_pkg::DESC_DEPTH)
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [OffW-1:0] wr_off_i,
  input  logic [OffW:0]   wr_len_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [OffW-1:0] rd_off_o,
  output logic [OffW:0]   rd_len_o
);
  import vfra_pkg::*;

  logic [OffW-1:0] mem_off [DescDepth];
  logic [OffW:0]   mem_len [DescDepth];
  logic [OffW-1:0] rd_off_q;
  logic [OffW:0]   rd_len_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_off[wr_addr_i] <= wr_off_i;
      mem_len[wr_addr_i] <= wr_len_i;
    end
  end

  // forward a same-cycle write to the entry about to become the head
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_off_q <= wr_off_i;
      rd_len_q <= wr_len_i;
    end else begin
      rd_off_q <= mem_off[rd_addr_i];
      rd_len_q <= mem_len[rd_addr_i];
    end
  end

  assign rd_off_o = rd_off_q;
  assign rd_len_o = rd_len_q;

endmodule

[src/vfra_ctrl.sv]
// Allocator state and per-operation logic: pool offsets, reservation, hold,
// descriptor queue pointers and the result of each executed operation.
// Depends on vfra_pkg.
module vfra_ctrl #(
  parameter int unsigned PoolBytes = vfra_pkg::POOL_BYTES,
  parameter int unsigned DescDepth = vfra_pkg::DESC_DEPTH,
  parameter int unsigned OffW      = $clog2(vfra_pkg::POOL_BYTES),
  parameter int unsigned IdxW      = $clog2(vfra_pkg::DESC_DEPTH),
  parameter int unsigned CntW      = $clog2(vfra_pkg::DESC_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              exec_i,
  input  vfra_pkg::op_e     op_i,
  input  logic [OffW:0]     bytes_i,
  input  logic [OffW:0]     pool_size_i,
  input  logic [CntW-1:0]   queue_limit_i,
  input  logic [OffW-1:0]   head_off_i,
  input  logic [OffW:0]     head_len_i,
  output logic              wr_en_o,
  output logic [IdxW-1:0]   wr_addr_o,
  output logic [OffW-1:0]   wr_off_o,
  output logic [OffW:0]     wr_len_o,
  output logic [IdxW-1:0]   rd_addr_o,
  output vfra_pkg::status_e status_o,
  output logic [OffW-1:0]   offset_o,
  output logic [OffW:0]     length_o,
  output logic [CntW-1:0]   count_o
);
  import vfra_pkg::*;

  localparam int unsigned LenW   = OffW + 1;
  localparam int unsigned DefLim = (DEFAULT_LIMIT > DescDepth) ? DescDepth : DEFAULT_LIMIT;
  localparam logic [LenW-1:0] PoolMax  = LenW'(PoolBytes);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DescDepth);
  localparam logic [CntW-1:0] DefCnt   = CntW'(DefLim);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DescDepth - 1);

  logic [LenW-1:0] front_q, front_d;
  logic [LenW-1:0] rear_q, rear_d;
  logic            res_valid_q, res_valid_d;
  logic [OffW-1:0] res_start_q, res_start_d;
  logic [LenW-1:0] res_len_q, res_len_d;
  logic            hold_q, hold_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  logic [LenW-1:0] pool_eff;
  logic [CntW-1:0] limit_eff;
  logic [LenW-1:0] tail_room;
  logic [LenW-1:0] gap_room;
  logic            fit_found;
  logic [OffW-1:0] fit_at;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    idx_inc = (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  always_comb begin
    if (pool_size_i == '0) begin
      pool_eff = LenW'(1);
    end else if (pool_size_i > PoolMax) begin
      pool_eff = PoolMax;
    end else begin
      pool_eff = pool_size_i;
    end
    if (queue_limit_i == '0) begin
      limit_eff = DefCnt;
    end else if (queue_limit_i > DepthCnt) begin
      limit_eff = DepthCnt;
    end else begin
      limit_eff = queue_limit_i;
    end
  end

  // free span search for a reserve: rear tail, wrap to zero, or gap to front
  always_comb begin
    tail_room = (pool_eff > rear_q) ? pool_eff - rear_q : '0;
    gap_room  = front_q - rear_q;
    fit_found = 1'b0;
    fit_at    = '0;
    if ((rear_q > front_q) || ((rear_q == front_q) && (count_q == '0))) begin
      if (tail_room >= bytes_i) begin
        fit_found = 1'b1;
        fit_at    = rear_q[OffW-1:0];
      end else if (front_q >= bytes_i) begin
        fit_found = 1'b1;
      end
    end else if (rear_q < front_q) begin
      if (gap_room >= bytes_i) begin
        fit_found = 1'b1;
        fit_at    = rear_q[OffW-1:0];
      end
    end
  end

  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    res_valid_d = res_valid_q;
    res_start_d = res_start_q;
    res_len_d   = res_len_q;
    hold_d      = hold_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    wr_en_o     = 1'b0;
    status_o    = ST_OK;
    offset_o    = '0;
    length_o    = '0;
    if (exec_i) begin
      unique case (op_i)
        OP_RESERVE: begin
          if (bytes_i == '0) begin
            status_o = ST_BAD_SIZE;
          end else if (!fit_found) begin
            status_o    = ST_NO_SPACE;
            res_valid_d = 1'b0;
          end else begin
            res_valid_d = 1'b1;
            res_start_d = fit_at;
            res_len_d   = bytes_i;
            offset_o    = fit_at;
          end
        end
        OP_COMMIT: begin
          if (!res_valid_q) begin
            status_o = ST_NO_RES;
          end else if ((bytes_i == '0) || (bytes_i > res_len_q)) begin
            status_o = ST_BAD_SIZE;
          end else if (count_q >= limit_eff) begin
            status_o = ST_FULL;
          end else begin
            wr_en_o     = 1'b1;
            tail_d      = idx_inc(tail_q);
            count_d     = count_q + CntW'(1);
            rear_d      = {1'b0, res_start_q} + bytes_i;
            res_valid_d = 1'b0;
            offset_o    = res_start_q;
          end
        end
        OP_CANCEL: begin
          if (!res_valid_q) begin
            status_o = ST_NO_RES;
          end else begin
            res_valid_d = 1'b0;
          end
        end
        OP_PEEK: begin
          hold_d = 1'b0;
          if (count_q == '0) begin
            status_o = ST_EMPTY;
          end else begin
            hold_d   = 1'b1;
            offset_o = head_off_i;
            length_o = head_len_i;
          end
        end
        OP_RELEASE: begin
          if (!hold_q) begin
            status_o = ST_NOT_HELD;
          end else if (count_q == '0) begin
            status_o = ST_EMPTY;
          end else begin
            front_d = {1'b0, head_off_i} + head_len_i;
            head_d  = idx_inc(head_q);
            count_d = count_q - CntW'(1);
            hold_d  = 1'b0;
          end
        end
        OP_UNHOLD: begin
          if (!hold_q) begin
            status_o = ST_NOT_HELD;
          end else begin
            hold_d = 1'b0;
          end
        end
        OP_CLEAR: begin
          front_d     = '0;
          rear_d      = '0;
          head_d      = '0;
          tail_d      = '0;
          count_d     = '0;
          res_valid_d = 1'b0;
          hold_d      = 1'b0;
        end
        default: begin
          // undefined code: no state change
        end
      endcase
    end
  end

  assign count_o   = count_d;
  assign wr_addr_o = tail_q;
  assign wr_off_o  = res_start_q;
  assign wr_len_o  = bytes_i;
  assign rd_addr_o = head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      rear_q      <= '0;
      res_valid_q <= 1'b0;
      res_start_q <= '0;
      res_len_q   <= '0;
      hold_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
    end else begin
      front_q     <= front_d;
      rear_q      <= rear_d;
      res_valid_q <= res_valid_d;
      res_start_q <= res_start_d;
      res_len_q   <= res_len_d;
      hold_q      <= hold_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

endmodule
